// File: hw/rtl/ccp_pkg.sv
// Package for the cosine colour palette: widths, register map, pipeline control
// type and the elaboration-time cosine sample function. No dependencies.
package ccp_pkg;

   localparam int DATA_W         = 16;   // one Q4.12 channel / palette position
   localparam int NUM_LANES      = 3;    // red, green, blue
   localparam int VEC_W          = DATA_W * NUM_LANES;
   localparam int NUM_STAGES     = 5;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_ADDR_W     = 5;    // four registers at 8-byte spacing
   localparam int CSR_IDX_W      = 2;
   localparam int COS_TABLE_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF      = 12;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FREQUENCY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE     = 2'd3;

   // 2*pi in unsigned Q34.30
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;   // load enable of each pipeline stage
   } pipe_ctl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] d;
   } lane_cfg_type;

   // |cos| of folded sample k (k within the first quarter turn), rounded to
   // fbits fraction bits. Taylor series to x^12 in Q2.30, each term truncated.
   function automatic logic [63:0] cos_mag(input int k, input int tbits, input int fbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint      sum;
      begin
         x    = (TWO_PI_Q30 * 64'(k)) >> tbits;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         sum  = longint'(64'd1 << 30);
         for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            case (n)
               1:       term = term / 64'd2;
               2:       term = term / 64'd12;
               3:       term = term / 64'd30;
               4:       term = term / 64'd56;
               5:       term = term / 64'd90;
               default: term = term / 64'd132;
            endcase
            if ((n % 2) == 1)
               sum = sum - longint'(term);
            else
               sum = sum + longint'(term);
         end
         if (sum < 0)
            sum = 0;
         return (64'(sum) + (64'd1 << (29 - fbits))) >> (30 - fbits);
      end
   endfunction

endpackage

// File: hw/rtl/ccp_cos_rom.sv
// Quarter-wave cosine magnitude ROM with registered read.
// Contents built at elaboration from ccp_pkg::cos_mag.
module ccp_cos_rom #(
   parameter int COS_TABLE_BITS = ccp_pkg::COS_TABLE_BITS_DEF,
   parameter int FRAC_BITS      = ccp_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [COS_TABLE_BITS-2:0] rd_addr,
   output logic [FRAC_BITS:0]        rd_data
);

   localparam int DEPTH = (2 ** (COS_TABLE_BITS - 2)) + 1;

   logic [FRAC_BITS:0] rom [DEPTH];
   logic [FRAC_BITS:0] rd_data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_rom
      localparam logic [63:0] MAG = ccp_pkg::cos_mag(i, COS_TABLE_BITS, FRAC_BITS);
      assign rom[i] = MAG[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= rom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ccp_csr.sv
// APB register file for the four packed palette vectors.
// Depends on ccp_pkg for the register map and widths.
module ccp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ccp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ccp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ccp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [ccp_pkg::VEC_W-1:0]       offset_vec,
   output logic [ccp_pkg::VEC_W-1:0]       amplitude_vec,
   output logic [ccp_pkg::VEC_W-1:0]       frequency_vec,
   output logic [ccp_pkg::VEC_W-1:0]       phase_vec
);

   logic [ccp_pkg::VEC_W-1:0]     offset_ff, amplitude_ff, frequency_ff, phase_ff;
   logic [ccp_pkg::CSR_IDX_W-1:0] idx;
   logic                          wr_en;
   logic [ccp_pkg::VEC_W-1:0]     rd_vec;

   assign idx        = csr_paddr[ccp_pkg::CSR_ADDR_W-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         amplitude_ff <= '0;
         frequency_ff <= '0;
         phase_ff     <= '0;
      end else if (wr_en) begin
         unique case (idx)
            ccp_pkg::REG_OFFSET:    offset_ff    <= csr_pwdata[ccp_pkg::VEC_W-1:0];
            ccp_pkg::REG_AMPLITUDE: amplitude_ff <= csr_pwdata[ccp_pkg::VEC_W-1:0];
            ccp_pkg::REG_FREQUENCY: frequency_ff <= csr_pwdata[ccp_pkg::VEC_W-1:0];
            ccp_pkg::REG_PHASE:     phase_ff     <= csr_pwdata[ccp_pkg::VEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         ccp_pkg::REG_OFFSET:    rd_vec = offset_ff;
         ccp_pkg::REG_AMPLITUDE: rd_vec = amplitude_ff;
         ccp_pkg::REG_FREQUENCY: rd_vec = frequency_ff;
         ccp_pkg::REG_PHASE:     rd_vec = phase_ff;
         default:                rd_vec = '0;
      endcase
   end

   assign csr_prdata    = ccp_pkg::CSR_DATA_W'(rd_vec);
   assign offset_vec    = offset_ff;
   assign amplitude_vec = amplitude_ff;
   assign frequency_vec = frequency_ff;
   assign phase_vec     = phase_ff;

endmodule

// File: hw/rtl/ccp_lane.sv
// One colour channel of the palette pipeline: phase multiply, fold, cosine
// lookup, amplitude multiply, offset and saturate. Uses ccp_pkg, ccp_cos_rom.
module ccp_lane #(
   parameter int COS_TABLE_BITS = ccp_pkg::COS_TABLE_BITS_DEF,
   parameter int FRAC_BITS      = ccp_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  ccp_pkg::pipe_ctl_type              ctl,
   input  ccp_pkg::lane_cfg_type              cfg,
   input  logic signed [ccp_pkg::DATA_W-1:0]  param_t,
   output logic signed [ccp_pkg::DATA_W-1:0]  chan_out
);

   localparam int PHASE_W = 2 * FRAC_BITS;
   localparam int IDX_W   = COS_TABLE_BITS;
   localparam int ADDR_W  = COS_TABLE_BITS - 1;
   localparam int SMP_W   = FRAC_BITS + 2;
   localparam int PROD_W  = SMP_W + ccp_pkg::DATA_W;
   localparam int CT_W    = 2 * ccp_pkg::DATA_W;

   localparam logic [IDX_W-1:0] HALF    = IDX_W'(1) << (IDX_W - 1);
   localparam logic [IDX_W-1:0] QUARTER = IDX_W'(1) << (IDX_W - 2);
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

   // stage 1: c * t
   logic signed [CT_W-1:0] ct_in, ct_ff;
   // stage 2: phase fraction, quadrant fold
   logic [PHASE_W-1:0]     phase_sum;
   logic [IDX_W-1:0]       idx, k_half, k_quad;
   logic                   neg_in;
   logic [ADDR_W-1:0]      addr_in, addr_ff;
   logic                   neg2_ff;
   // stage 3: table read
   logic [FRAC_BITS:0]     mag;
   logic                   neg3_ff;
   // stage 4: scale by amplitude
   logic signed [SMP_W-1:0]  smp;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   // stage 5: round, offset, saturate
   logic signed [PROD_W-1:0] rnd, sum;
   logic signed [ccp_pkg::DATA_W-1:0] chan_in, chan_ff;

   assign ct_in = cfg.c * param_t;

   always_ff @(posedge clock) begin
      if (ctl.en[0])
         ct_ff <= ct_in;
   end

   // whole turns drop out; only the top table bits of the fraction survive
   assign phase_sum = ct_ff[PHASE_W-1:0] + {cfg.d[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
   assign idx       = phase_sum[PHASE_W-1 -: IDX_W];

   always_comb begin
      k_half = (idx > HALF) ? (IDX_W'(0) - idx) : idx;
      neg_in = (k_half > QUARTER);
      k_quad = neg_in ? (HALF - k_half) : k_half;
      addr_in = k_quad[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         addr_ff <= addr_in;
         neg2_ff <= neg_in;
      end
   end

   ccp_cos_rom #(
      .COS_TABLE_BITS (COS_TABLE_BITS),
      .FRAC_BITS      (FRAC_BITS)
   ) u_rom (
      .clock   (clock),
      .rd_en   (ctl.en[2]),
      .rd_addr (addr_ff),
      .rd_data (mag)
   );

   always_ff @(posedge clock) begin
      if (ctl.en[2])
         neg3_ff <= neg2_ff;
   end

   always_comb begin
      smp     = neg3_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      prod_in = PROD_W'(smp) * PROD_W'(cfg.b);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[3])
         prod_ff <= prod_in;
   end

   // round half up, then arithmetic shift gives floor
   always_comb begin
      rnd = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
      sum = rnd + PROD_W'(cfg.a);
      if (sum > SAT_HI)
         chan_in = sum[ccp_pkg::DATA_W-1:0] & 16'sd0 | 16'sh7FFF;
      else if (sum < SAT_LO)
         chan_in = 16'sh8000;
      else
         chan_in = sum[ccp_pkg::DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.en[4])
         chan_ff <= chan_in;
   end

   assign chan_out = chan_ff;

endmodule

// File: hw/rtl/cosine_color_palette_top.sv
// Top level of the cosine colour palette: APB registers, stage valid/ready
// chain and three channel pipelines. Uses ccp_pkg, ccp_csr, ccp_lane.
//
//   port group | role            | payload
//   req_*      | stream in       | tdata[15:0] param_t
//   rsp_*      | stream out      | tdata[15:0] red_out, [31:16] green_out, [47:32] blue_out
//   csr_*      | APB registers   | 64-bit data, registers at 8-byte spacing
//
// One beat per cycle in and out while rsp_tready is high; five register stages (phase
// multiply, fold, registered table read, amplitude multiply, saturate) lie between an
// accepted beat and rsp_tvalid.
// Reset clears the stage valid bits and all four registers; no clearing pass.
// A stage holds while the one after it is full and not moving, so bubbles
// close up and a stalled output still lets new beats in until the pipe fills.
module cosine_color_palette_top #(
   parameter int COS_TABLE_BITS = ccp_pkg::COS_TABLE_BITS_DEF,
   parameter int FRAC_BITS      = ccp_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ccp_pkg::DATA_W-1:0]      req_tdata,   // [15:0] param_t
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ccp_pkg::VEC_W-1:0]       rsp_tdata,   // red_out, green_out, blue_out
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ccp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ccp_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ccp_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int N  = ccp_pkg::NUM_STAGES;
   localparam int DW = ccp_pkg::DATA_W;

   logic [ccp_pkg::VEC_W-1:0] offset_vec, amplitude_vec, frequency_vec, phase_vec;
   logic [N-1:0]              valid_ff, valid_in;
   ccp_pkg::pipe_ctl_type     ctl;

   ccp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .offset_vec    (offset_vec),
      .amplitude_vec (amplitude_vec),
      .frequency_vec (frequency_vec),
      .phase_vec     (phase_vec)
   );

   always_comb begin
      ctl.en[N-1] = !valid_ff[N-1] || rsp_tready;
      for (int k = N - 2; k >= 0; k--)
         ctl.en[k] = !valid_ff[k] || ctl.en[k+1];
      valid_in[0] = ctl.en[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < N; k++)
         valid_in[k] = ctl.en[k] ? valid_ff[k-1] : valid_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= '0;
      else
         valid_ff <= valid_in;
   end

   assign req_tready = ctl.en[0];
   assign rsp_tvalid = valid_ff[N-1];

   for (genvar i = 0; i < ccp_pkg::NUM_LANES; i++) begin : g_lane
      ccp_pkg::lane_cfg_type cfg;
      logic signed [DW-1:0]  chan;

      assign cfg.a = offset_vec[DW*i +: DW];
      assign cfg.b = amplitude_vec[DW*i +: DW];
      assign cfg.c = frequency_vec[DW*i +: DW];
      assign cfg.d = phase_vec[DW*i +: DW];

      ccp_lane #(
         .COS_TABLE_BITS (COS_TABLE_BITS),
         .FRAC_BITS      (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .ctl      (ctl),
         .cfg      (cfg),
         .param_t  ($signed(req_tdata)),
         .chan_out (chan)
      );

      assign rsp_tdata[DW*i +: DW] = chan;
   end

`ifndef SYNTHESIS
   // an empty first stage never blocks the input
   assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_tready)
      else $error("input blocked with empty first stage");

   // an accepted beat lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted beat lost at entry");

   // stalled output: the beat behind it must stay put
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[N-1] && !rsp_tready && valid_ff[N-2]) |=> valid_ff[N-2])
      else $error("beat dropped behind stalled output");
`endif

endmodule

// File: verif/cosine_color_palette_top_tb.sv
// Testbench for cosine_color_palette_top: a self-checking colour predictor fed over the
// req/rsp streams and APB registers, with random idling on both sides. Needs ccp_pkg and
// the palette RTL only.
module cosine_color_palette_top_tb;

   localparam int FRAC       = ccp_pkg::FRAC_BITS_DEF;
   localparam int TABLE_BITS = ccp_pkg::COS_TABLE_BITS_DEF;

   typedef struct packed {
      logic signed [15:0] blue;
      logic signed [15:0] green;
      logic signed [15:0] red;
   } colour_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [ccp_pkg::DATA_W-1:0]       req_tdata;    // [15:0] param_t
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // [15:0] red_out, [31:16] green_out, [47:32] blue_out
   logic [ccp_pkg::VEC_W-1:0]        rsp_tdata;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [ccp_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [ccp_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [ccp_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   logic [ccp_pkg::VEC_W-1:0]        palette_cfg [4];
   colour_type                       colour_q [$];
   int                               error_count;
   int                               send_idle_pct;
   int                               stall_pct;

   cosine_color_palette_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // cosine of sample idx out of one turn, Q4.12
   function automatic logic signed [15:0] cos_point(input logic [TABLE_BITS-1:0] idx);
      logic [63:0] k;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] mag;
      longint      acc;
      bit          neg;
      begin
         k   = 64'(idx);
         neg = 1'b0;
         if (k > (64'd1 << (TABLE_BITS - 1)))
            k = (64'd1 << TABLE_BITS) - k;
         if (k > (64'd1 << (TABLE_BITS - 2))) begin
            k   = (64'd1 << (TABLE_BITS - 1)) - k;
            neg = 1'b1;
         end
         x    = (ccp_pkg::TWO_PI_Q30 * k) >> TABLE_BITS;
         x2   = (x * x) >> 30;
         term = 64'd1 << 30;
         acc  = longint'(64'd1 << 30);
         for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
               acc = acc - longint'(term);
            else
               acc = acc + longint'(term);
         end
         if (acc < 0)
            acc = 0;
         mag = (64'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
         return neg ? -16'(mag) : 16'(mag);
      end
   endfunction

   function automatic logic signed [15:0] channel_value(input logic signed [15:0] t,
         input logic signed [15:0] a, input logic signed [15:0] b,
         input logic signed [15:0] c, input logic signed [15:0] d);
      longint ph;
      longint prod;
      longint v;
      begin
         ph   = longint'(c) * longint'(t) + (longint'(d) <<< FRAC);
         // whole turns drop out; the top fraction bits pick the sample
         prod = longint'(cos_point(ph[2*FRAC-1 -: TABLE_BITS])) * longint'(b);
         v    = ((prod + (longint'(1) <<< (FRAC - 1))) >>> FRAC) + longint'(a);
         if (v > 32767)
            v = 32767;
         if (v < -32768)
            v = -32768;
         return v[15:0];
      end
   endfunction

   function automatic colour_type predict_colour(input logic signed [15:0] t);
      logic signed [15:0] ch_val [3];
      colour_type         res;
      begin
         for (int ch = 0; ch < 3; ch++)
            ch_val[ch] = channel_value(t, palette_cfg[ccp_pkg::REG_OFFSET][16*ch +: 16],
                                       palette_cfg[ccp_pkg::REG_AMPLITUDE][16*ch +: 16],
                                       palette_cfg[ccp_pkg::REG_FREQUENCY][16*ch +: 16],
                                       palette_cfg[ccp_pkg::REG_PHASE][16*ch +: 16]);
         res.red   = ch_val[0];
         res.green = ch_val[1];
         res.blue  = ch_val[2];
         return res;
      end
   endfunction

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      colour_type got;
      colour_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[15:0];
         got.green = rsp_tdata[31:16];
         got.blue  = rsp_tdata[47:32];
         if (colour_q.size() == 0) begin
            $error("rsp beat with no colour pending: %h", rsp_tdata);
            error_count++;
         end else begin
            want = colour_q.pop_front();
            if (got.red !== want.red) begin
               $error("red_out: expected %0d, got %0d", want.red, got.red);
               error_count++;
            end
            if (got.green !== want.green) begin
               $error("green_out: expected %0d, got %0d", want.green, got.green);
               error_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // ---------------------------------------------------------------- drivers

   function automatic logic [ccp_pkg::VEC_W-1:0] pack_lanes(input logic [15:0] r,
         input logic [15:0] g, input logic [15:0] b);
      return {b, g, r};
   endfunction

   // upper pwdata bits carry junk; the register keeps only 48 bits
   task automatic write_palette_reg(input logic [ccp_pkg::CSR_IDX_W-1:0] idx,
         input logic [ccp_pkg::VEC_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= {16'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      palette_cfg[idx] = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // bus returns to idle before the next transfer
      @(posedge clock);
   endtask

   task automatic send_param(input logic [15:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      do
         @(posedge clock);
      while (!req_tready);
      colour_q.push_back(predict_colour(t));
   endtask

   // sender holds off until every pending colour is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (colour_q.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [15:0] random_lane();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_param();
      case ($urandom_range(19))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      send_param(16'h0000);
      send_param(16'h7FFF);
      send_param(16'h8000);
      wait_drained();
   endtask

   task automatic test_directed_points();
      logic [15:0] pts [9];
      pts = '{16'h0000, 16'h0400, 16'h0800, 16'h0C00, 16'h1000,
              16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
      write_palette_reg(ccp_pkg::REG_OFFSET,
                        pack_lanes(16'h0800, 16'h1000, 16'hF000));
      write_palette_reg(ccp_pkg::REG_AMPLITUDE,
                        pack_lanes(16'h0800, 16'hF800, 16'h2000));
      // blue at full-scale frequency wraps the phase many turns
      write_palette_reg(ccp_pkg::REG_FREQUENCY,
                        pack_lanes(16'h1000, 16'h2000, 16'h7FFF));
      write_palette_reg(ccp_pkg::REG_PHASE,
                        pack_lanes(16'h0000, 16'h0400, 16'h8000));
      foreach (pts[i])
         send_param(pts[i]);
      wait_drained();
   endtask

   task automatic test_saturation();
      // red clips high, green and blue clip low
      write_palette_reg(ccp_pkg::REG_OFFSET,
                        pack_lanes(16'h7FFF, 16'h8000, 16'h8000));
      write_palette_reg(ccp_pkg::REG_AMPLITUDE,
                        pack_lanes(16'h7FFF, 16'h7FFF, 16'h8000));
      write_palette_reg(ccp_pkg::REG_FREQUENCY,
                        pack_lanes(16'h0000, 16'h0000, 16'h0000));
      write_palette_reg(ccp_pkg::REG_PHASE,
                        pack_lanes(16'h0000, 16'h0800, 16'h0000));
      send_param(16'h0000);
      send_param(16'h1234);
      send_param(16'h8000);
      wait_drained();
   endtask

   task automatic run_random_phase(input int idle_in, input int stall_out,
         input int per_setting);
      send_idle_pct = idle_in;
      stall_pct     = stall_out;
      for (int s = 0; s < 2; s++) begin
         for (int r = 0; r < 4; r++)
            write_palette_reg(ccp_pkg::CSR_IDX_W'(r),
                              pack_lanes(random_lane(), random_lane(), random_lane()));
         for (int i = 0; i < per_setting; i++)
            send_param(random_param());
         wait_drained();
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(0,  0,  117);
      run_random_phase(81, 0,  117);
      run_random_phase(0,  81, 117);
      run_random_phase(10, 10, 117);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      rsp_tready    <= 1'b0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      error_count   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;
      foreach (palette_cfg[i])
         palette_cfg[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_points();
      test_saturation();
      test_random_traffic();

      wait_drained();
      repeat (ccp_pkg::NUM_STAGES + 10) @(posedge clock);
      if (error_count == 0 && colour_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #(8 * 400000);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_cos_rom.sv
hw/rtl/ccp_csr.sv
hw/rtl/ccp_lane.sv
hw/rtl/cosine_color_palette_top.sv
verif/cosine_color_palette_top_tb.sv
